[design/text_console_writer_assert.svh]
// Assertion macros for the text console writer checker.
// Depends on nothing; included by the checker file only.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define TCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block but tcw_ram.
package tcw_pkg;

    // Field widths of the command and result words
    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int X_W    = 7;
    localparam int Y_W    = 5;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Default geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Character and color codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT        = 3'd0,
        CMD_CLR_LINE   = 3'd1,
        CMD_CLR_SCREEN = 3'd2,
        CMD_READ       = 3'd3,
        CMD_WRITE      = 3'd4
    } t_cmd;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch a new command word
        logic put;         // store char at cursor and advance
        logic cell_write;  // write cell at given position
        logic scroll_setup;
        logic clr_line;
        logic clr_screen;
        logic prime_read;  // first read of the scroll copy
        logic sweep;       // one write of a row or screen walk
        logic init_attr;   // blank with the reset color
        logic finish;      // load the result registers
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic scroll_needed;
        logic sweep_last;
    } t_dp_status;

endpackage

[design/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the console cell store.
module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tcw_ctrl.sv]
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath through t_dp_cmd.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_PRIME,
        S_SWEEP,
        S_READ
    } t_state;

    t_state  r_state, n_state;
    logic    r_done, n_done;
    t_dp_cmd cmd;

    // Decode state and status into datapath commands
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                cmd.sweep     = 1'b1;
                cmd.init_attr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.load = i_start;
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_status.cmd)
                    CMD_PUT: begin
                        cmd.put = 1'b1;
                        if (i_status.scroll_needed) begin
                            cmd.scroll_setup = 1'b1;
                            n_state          = S_PRIME;
                        end else begin
                            cmd.finish = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    CMD_CLR_LINE: begin
                        cmd.clr_line = 1'b1;
                        n_state      = S_SWEEP;
                    end
                    CMD_CLR_SCREEN: begin
                        cmd.clr_screen = 1'b1;
                        n_state        = S_SWEEP;
                    end
                    CMD_READ: begin
                        n_state = S_READ;
                    end
                    CMD_WRITE: begin
                        cmd.cell_write = 1'b1;
                        cmd.finish     = 1'b1;
                        n_state        = S_IDLE;
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_PRIME: begin
                cmd.prime_read = 1'b1;
                n_state        = S_SWEEP;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_READ: begin
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_done = cmd.finish;
    end

    // Hold state and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

[design/tcw_datapath.sv]
// Datapath of the text console writer: cell store, cursor, sweep counter.
// Depends on tcw_pkg and tcw_ram; steered by tcw_ctrl.
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ATTR_W-1:0] i_attribute,
    input  logic [X_W-1:0]    i_x_pos,
    input  logic [Y_W-1:0]    i_y_pos,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    output logic [CELL_W-1:0] o_cell_data,
    output logic [Y_W-1:0]    o_cursor_row,
    output logic [X_W-1:0]    o_cursor_col,
    output logic              o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_A     = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END_A = AW'(CELLS - COLUMNS);

    // Latched command word
    t_cmd              r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic [ATTR_W-1:0] r_attr;
    logic [X_W-1:0]    r_x;
    logic [Y_W-1:0]    r_y;

    logic [ATTR_W-1:0] r_text_color;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [AW-1:0]     r_waddr;
    logic [AW-1:0]     r_end;
    logic              r_copy;
    logic [CELL_W-1:0] r_cell_data;
    logic              r_scroll;

    logic              in_range;
    logic              newline;
    logic [COL_W:0]    col_inc;
    logic              wrap;
    logic              row_last;
    logic              scroll_needed;
    logic              sweep_last;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     row_base;
    logic [AW-1:0]     xy_addr;
    logic [AW:0]       copy_sum;
    logic [AW-1:0]     copy_raddr;
    logic [ATTR_W-1:0] blank_attr;
    logic [CELL_W-1:0] sweep_data;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [CELL_W-1:0] rdata;

    // Cursor advance and position decode
    always_comb begin
        in_range      = (int'(r_x) < COLUMNS) && (int'(r_y) < ROWS);
        newline       = (r_char == NEWLINE_CODE);
        col_inc       = {1'b0, r_col} + 1'b1;
        wrap          = (col_inc == (COL_W+1)'(COLUMNS)) || newline;
        row_last      = (r_row == ROW_W'(ROWS - 1));
        scroll_needed = wrap && row_last;
        sweep_last    = (r_waddr == r_end);
        cur_addr      = AW'(r_row) * COLS_A + AW'(r_col);
        row_base      = AW'(r_row) * COLS_A;
        xy_addr       = in_range ? (AW'(r_y) * COLS_A + AW'(r_x)) : '0;
        copy_sum      = {1'b0, r_waddr} + (AW+1)'(COLUMNS + 1);
        copy_raddr    = (copy_sum >= (AW+1)'(CELLS)) ? '0 : copy_sum[AW-1:0];
    end

    // Select the write and read ports of the cell store
    always_comb begin
        blank_attr = i_cmd.init_attr ? RESET_COLOR : r_text_color;
        sweep_data = (r_copy && (r_waddr < COPY_END_A)) ? rdata
                                                        : {blank_attr, SPACE_CODE};
        we    = 1'b0;
        waddr = r_waddr;
        wdata = sweep_data;
        if (i_cmd.put && !newline) begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {r_text_color, r_char};
        end else if (i_cmd.cell_write && in_range) begin
            we    = 1'b1;
            waddr = xy_addr;
            wdata = {r_attr, r_char};
        end else if (i_cmd.sweep) begin
            we = 1'b1;
        end

        if (i_cmd.prime_read) begin
            raddr = COLS_A;
        end else if (i_cmd.sweep && r_copy) begin
            raddr = copy_raddr;
        end else begin
            raddr = xy_addr;
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Latch the command word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_PUT;
        end else if (i_cmd.load) begin
            r_cmd <= t_cmd'(i_command);
        end
        if (i_cmd.load) begin
            r_char <= i_char_code;
            r_attr <= i_attribute;
            r_x    <= i_x_pos;
            r_y    <= i_y_pos;
        end
    end

    // Color register, cursor, sweep counter and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
            r_row        <= '0;
            r_col        <= '0;
            r_waddr      <= '0;
            r_end        <= LAST_A;
            r_copy       <= 1'b0;
            r_cell_data  <= '0;
            r_scroll     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_text_color <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_scroll <= 1'b0;
            end
            if (i_cmd.put) begin
                r_col    <= wrap ? '0 : col_inc[COL_W-1:0];
                r_scroll <= scroll_needed;
                if (wrap && !row_last) begin
                    r_row <= r_row + 1'b1;
                end
            end
            if (i_cmd.scroll_setup) begin
                r_waddr <= '0;
                r_end   <= LAST_A;
                r_copy  <= 1'b1;
            end
            if (i_cmd.clr_line) begin
                r_col   <= '0;
                r_waddr <= row_base;
                r_end   <= row_base + AW'(COLUMNS - 1);
                r_copy  <= 1'b0;
            end
            if (i_cmd.clr_screen) begin
                r_row   <= '0;
                r_col   <= '0;
                r_waddr <= '0;
                r_end   <= LAST_A;
                r_copy  <= 1'b0;
            end
            if (i_cmd.sweep && !sweep_last) begin
                r_waddr <= r_waddr + 1'b1;
            end
            if (i_cmd.finish) begin
                r_cell_data <= ((r_cmd == CMD_READ) && in_range) ? rdata : '0;
            end
        end
    end

    assign o_status.cmd           = r_cmd;
    assign o_status.scroll_needed = scroll_needed;
    assign o_status.sweep_last    = sweep_last;

    assign o_cell_data  = r_cell_data;
    assign o_cursor_row = Y_W'(r_row);
    assign o_cursor_col = X_W'(r_col);
    assign o_scrolled   = r_scroll;

endmodule

[design/text_console_writer.sv]
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and tcw_ram.
//
// Usage: drive a command word (command, char_code, attribute, x_pos, y_pos)
// with i_start; it is taken at a clock edge where i_start is high and
// o_busy is low. One result word follows, shown for a single cycle with
// o_done high; the receiver cannot stall it. The cursor ports always show
// the cursor after the last command. i_cfg_we writes the text color at any
// edge; write it while the block is idle.
// Put char, write cell and unused codes finish in the execute state; read
// cell adds S_READ, since the read of the cell RAM is registered. Clear
// line walks the cursor row and clear screen the whole screen; a put char
// that scrolls primes the copy read in S_PRIME and then walks the screen.
// o_done is high in the same cycle in which o_busy has returned low.
// Row walks and the scroll copy move one cell a cycle through the single
// write port of the cell RAM.
// After reset the block fills all ROWS*COLUMNS cells (2000 by default)
// with spaces in color 7, one cell a cycle, with o_busy high.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ATTR_W-1:0] i_attribute,
    input  logic [X_W-1:0]    i_x_pos,
    input  logic [Y_W-1:0]    i_y_pos,
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    output logic              o_done,
    output logic [CELL_W-1:0] o_cell_data,
    output logic [Y_W-1:0]    o_cursor_row,
    output logic [X_W-1:0]    o_cursor_col,
    output logic              o_scrolled
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       busy;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_attribute  (i_attribute),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_cell_data  (o_cell_data),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled)
    );

    assign o_busy = busy;

endmodule

[design/tcw_checker.sv]
// Port-level checks on the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_assert.svh.
`include "text_console_writer_assert.svh"

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input logic           o_done,
    input logic           o_scrolled,
    input logic [Y_W-1:0] o_cursor_row,
    input logic [X_W-1:0] o_cursor_col
);

    // An accepted word makes the block busy in the next cycle
    `TCW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accept without busy")

    // Results appear only once the block is idle again
    `TCW_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "done while busy")

    // The result strobe lasts one cycle
    `TCW_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "done held two cycles")

    // A scroll leaves the cursor at the start of the last row
    `TCW_ASSERT_IMPL(a_scroll_cursor, i_clk, i_rst_n, o_done && o_scrolled, (o_cursor_col == '0) && (o_cursor_row == Y_W'(ROWS - 1)), "cursor misplaced after scroll")

endmodule

bind text_console_writer tcw_checker #(
    .ROWS (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_done       (o_done),
    .o_scrolled   (o_scrolled),
    .o_cursor_row (o_cursor_row),
    .o_cursor_col (o_cursor_col)
);
